// ===== hw/rtl/taylor_sine_cosine_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sine/cosine block checker
// ----------------------------------------------------------------------------
`ifndef TAYLOR_SINE_COSINE_TOP_MACROS_SVH
`define TAYLOR_SINE_COSINE_TOP_MACROS_SVH

// same-cycle implication, sampled on aclk, off during reset
`define TSC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tsc checker: same-cycle property violated");

// next-cycle implication, sampled on aclk, off during reset
`define TSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tsc checker: next-cycle property violated");

`endif

// ===== hw/rtl/tsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types and constants for the Taylor sine/cosine pipeline.
// ----------------------------------------------------------------------------
package tsc_pkg;

    localparam int ANGLE_BITS_DEF       = 16;
    localparam int RESULT_FRAC_BITS_DEF = 14;

    // internal working fraction
    localparam int WFRAC   = 30;
    localparam int X_W     = 31;   // x in Q30, up to pi/2
    localparam int X2_W    = 32;   // x^2 in Q30
    localparam int P_W     = 33;   // x^3 or x^4 in Q30
    localparam int M_W     = 32;   // dividend for the divide-by-3 step
    localparam int Q_W     = 31;   // quotient
    localparam int Y_W     = 34;   // polynomial sum
    localparam int VALUE_W = 16;

    localparam logic [X_W-1:0]     HALF_PI_Q30 = 31'd1686629713;
    // floor(m/3) == (m * RECIP3) >> 33 for every 32-bit m
    localparam logic [M_W-1:0]     RECIP3      = 32'hAAAA_AAAB;
    localparam logic [VALUE_W-1:0] SAT_MAG     = 16'd32767;
    localparam logic [3:0]         RND_DIV24   = 4'd12;
    localparam logic [3:0]         RND_DIV6    = 4'd3;

    typedef struct packed {
        logic vld;
        logic is_cos;
        logic neg;
    } ctrl_t;

endpackage

// ===== hw/rtl/tsc_fold.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_fold
// Quadrant folding and conversion of the reduced angle to radians (Q30).
// ----------------------------------------------------------------------------
module tsc_fold #(
    parameter int ANGLE_BITS = tsc_pkg::ANGLE_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_vld,
    input  logic                    op,
    input  logic [ANGLE_BITS-1:0]   angle,
    output tsc_pkg::ctrl_t          ctrl_out,
    output logic [tsc_pkg::X_W-1:0] x_out
);

    localparam int T_W  = ANGLE_BITS - 1;
    localparam int PR_W = T_W + tsc_pkg::X_W;
    localparam logic [T_W-1:0]  QUARTER = T_W'(1) << (ANGLE_BITS - 2);
    localparam logic [PR_W-1:0] X_RND   = PR_W'(1) << (ANGLE_BITS - 3);

    logic [1:0]            quad;
    logic [1:0]            quad_adj;
    logic [ANGLE_BITS-3:0] r;
    logic [T_W-1:0]        t_next;
    tsc_pkg::ctrl_t        c1_next;

    logic [T_W-1:0]        t_reg;
    tsc_pkg::ctrl_t        c1_reg;
    logic [PR_W-1:0]       xprod;
    logic [tsc_pkg::X_W-1:0] x_next;
    logic [tsc_pkg::X_W-1:0] x_reg;
    tsc_pkg::ctrl_t        c2_reg;

    assign quad = angle[ANGLE_BITS-1 -: 2];
    assign r    = angle[ANGLE_BITS-3:0];

    // a boundary at a quarter or three-quarter turn belongs to the quadrant below
    assign quad_adj = (r == '0 && quad[0]) ? quad - 2'd1 : quad;
    // Q - 0 gives Q, so the boundary needs no special t
    assign t_next   = quad[0] ? QUARTER - {1'b0, r} : {1'b0, r};

    always_comb begin
        c1_next.vld    = in_vld;
        c1_next.is_cos = op;
        c1_next.neg    = op ? (quad_adj == 2'd1 || quad_adj == 2'd2) : quad_adj[1];
    end

    assign xprod  = {{tsc_pkg::X_W{1'b0}}, t_reg} * {{T_W{1'b0}}, tsc_pkg::HALF_PI_Q30}
                  + X_RND;
    assign x_next = xprod[ANGLE_BITS-2 +: tsc_pkg::X_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg <= '0;
            c2_reg <= '0;
        end else if (en) begin
            c1_reg <= c1_next;
            c2_reg <= c1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg <= t_next;
            x_reg <= x_next;
        end
    end

    assign ctrl_out = c2_reg;
    assign x_out    = x_reg;

endmodule

// ===== hw/rtl/tsc_pow.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_pow
// Powers of x: x^2, then x^3 (sine) or x^4 (cosine) on a second, shared multiplier.
// ----------------------------------------------------------------------------
module tsc_pow (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  tsc_pkg::ctrl_t           ctrl_in,
    input  logic [tsc_pkg::X_W-1:0]  x_in,
    output tsc_pkg::ctrl_t           ctrl_out,
    output logic [tsc_pkg::X_W-1:0]  x_out,
    output logic [tsc_pkg::X2_W-1:0] x2_out,
    output logic [tsc_pkg::P_W-1:0]  p_out
);

    localparam int SQ_W = 2 * tsc_pkg::X_W;
    localparam int PP_W = 2 * tsc_pkg::X2_W;
    localparam logic [SQ_W-1:0] SQ_RND = SQ_W'(1) << (tsc_pkg::WFRAC - 1);
    localparam logic [PP_W-1:0] PP_RND = PP_W'(1) << (tsc_pkg::WFRAC - 1);

    logic [SQ_W-1:0]           sq;
    logic [tsc_pkg::X2_W-1:0]  x2_next;
    logic [tsc_pkg::X2_W-1:0]  mul_b;
    logic [PP_W-1:0]           pp;
    logic [tsc_pkg::P_W-1:0]   p_next;

    tsc_pkg::ctrl_t            c3_reg;
    tsc_pkg::ctrl_t            c4_reg;
    logic [tsc_pkg::X_W-1:0]   x3_reg;
    logic [tsc_pkg::X_W-1:0]   x4_reg;
    logic [tsc_pkg::X2_W-1:0]  x2_reg;
    logic [tsc_pkg::X2_W-1:0]  x2d_reg;
    logic [tsc_pkg::P_W-1:0]   p_reg;

    assign sq      = {{tsc_pkg::X_W{1'b0}}, x_in} * {{tsc_pkg::X_W{1'b0}}, x_in} + SQ_RND;
    assign x2_next = sq[tsc_pkg::WFRAC +: tsc_pkg::X2_W];

    // cosine: x2*x2, sine: x2*x
    assign mul_b  = c3_reg.is_cos ? x2_reg : {1'b0, x3_reg};
    assign pp     = {{tsc_pkg::X2_W{1'b0}}, x2_reg} * {{tsc_pkg::X2_W{1'b0}}, mul_b} + PP_RND;
    assign p_next = pp[tsc_pkg::WFRAC +: tsc_pkg::P_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c3_reg <= '0;
            c4_reg <= '0;
        end else if (en) begin
            c3_reg <= ctrl_in;
            c4_reg <= c3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x3_reg  <= x_in;
            x2_reg  <= x2_next;
            x4_reg  <= x3_reg;
            x2d_reg <= x2_reg;
            p_reg   <= p_next;
        end
    end

    assign ctrl_out = c4_reg;
    assign x_out    = x4_reg;
    assign x2_out   = x2d_reg;
    assign p_out    = p_reg;

endmodule

// ===== hw/rtl/tsc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_div
// Rounded divides: x^3/6 or x^4/24 by shift plus reciprocal-of-3 multiply,
// and x^2/2 by shift.
// ----------------------------------------------------------------------------
module tsc_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  tsc_pkg::ctrl_t           ctrl_in,
    input  logic [tsc_pkg::X_W-1:0]  x_in,
    input  logic [tsc_pkg::X2_W-1:0] x2_in,
    input  logic [tsc_pkg::P_W-1:0]  p_in,
    output tsc_pkg::ctrl_t           ctrl_out,
    output logic [tsc_pkg::X_W-1:0]  x_out,
    output logic [tsc_pkg::X2_W-1:0] h2_out,
    output logic [tsc_pkg::Q_W-1:0]  q_out
);

    localparam int S_W  = tsc_pkg::P_W + 1;
    localparam int RP_W = 2 * tsc_pkg::M_W;

    logic [S_W-1:0]             s;
    logic [tsc_pkg::M_W-1:0]    m_next;
    logic [tsc_pkg::X2_W:0]     h2_sum;
    logic [tsc_pkg::X2_W-1:0]   h2_next;
    logic [RP_W-1:0]            rp;
    logic [tsc_pkg::Q_W-1:0]    q_next;

    tsc_pkg::ctrl_t             c5_reg;
    tsc_pkg::ctrl_t             c6_reg;
    logic [tsc_pkg::M_W-1:0]    m_reg;
    logic [tsc_pkg::X2_W-1:0]   h2_reg;
    logic [tsc_pkg::X2_W-1:0]   h2d_reg;
    logic [tsc_pkg::X_W-1:0]    x5_reg;
    logic [tsc_pkg::X_W-1:0]    x6_reg;
    logic [tsc_pkg::Q_W-1:0]    q_reg;

    // /24 = /8 then /3, /6 = /2 then /3; rounding bias added first
    assign s = {1'b0, p_in}
             + (ctrl_in.is_cos ? S_W'(tsc_pkg::RND_DIV24) : S_W'(tsc_pkg::RND_DIV6));
    assign m_next = ctrl_in.is_cos ? {1'b0, s[S_W-1:3]} : s[tsc_pkg::M_W:1];

    assign h2_sum  = {1'b0, x2_in} + {{tsc_pkg::X2_W{1'b0}}, 1'b1};
    assign h2_next = h2_sum[tsc_pkg::X2_W:1];

    assign rp     = {{tsc_pkg::M_W{1'b0}}, m_reg} * {{tsc_pkg::M_W{1'b0}}, tsc_pkg::RECIP3};
    assign q_next = rp[RP_W-1 -: tsc_pkg::Q_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c5_reg <= '0;
            c6_reg <= '0;
        end else if (en) begin
            c5_reg <= ctrl_in;
            c6_reg <= c5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg   <= m_next;
            h2_reg  <= h2_next;
            x5_reg  <= x_in;
            q_reg   <= q_next;
            h2d_reg <= h2_reg;
            x6_reg  <= x5_reg;
        end
    end

    assign ctrl_out = c6_reg;
    assign x_out    = x6_reg;
    assign h2_out   = h2d_reg;
    assign q_out    = q_reg;

endmodule

// ===== hw/rtl/tsc_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_out
// Polynomial sum, rounding to the result format, saturation and sign.
// ----------------------------------------------------------------------------
module tsc_out #(
    parameter int RESULT_FRAC_BITS = tsc_pkg::RESULT_FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  tsc_pkg::ctrl_t              ctrl_in,
    input  logic [tsc_pkg::X_W-1:0]     x_in,
    input  logic [tsc_pkg::X2_W-1:0]    h2_in,
    input  logic [tsc_pkg::Q_W-1:0]     q_in,
    output logic                        vld_out,
    output logic [tsc_pkg::VALUE_W-1:0] value_out
);

    localparam int Y_W = tsc_pkg::Y_W;
    localparam int SH  = tsc_pkg::WFRAC - RESULT_FRAC_BITS;
    localparam logic [Y_W-1:0] ONE_Q30 = Y_W'(1) << tsc_pkg::WFRAC;
    localparam logic [Y_W-1:0] Y_RND   = Y_W'(1) << (SH - 1);

    logic [Y_W-1:0]              y;
    logic [Y_W-1:0]              y_rnd;
    logic [Y_W-1:0]              mag_full;
    logic [tsc_pkg::VALUE_W-1:0] mag;
    logic [tsc_pkg::VALUE_W-1:0] value_next;

    logic                        vld_reg;
    logic [tsc_pkg::VALUE_W-1:0] value_reg;

    always_comb begin
        if (ctrl_in.is_cos) begin
            y = ONE_Q30 - Y_W'(h2_in) + Y_W'(q_in);
        end else begin
            y = Y_W'(x_in) - Y_W'(q_in);
        end
        y_rnd    = y + Y_RND;
        mag_full = y_rnd >> SH;
        mag      = (mag_full > Y_W'(tsc_pkg::SAT_MAG)) ? tsc_pkg::SAT_MAG
                                                      : mag_full[tsc_pkg::VALUE_W-1:0];
        value_next = ctrl_in.neg ? (tsc_pkg::VALUE_W'(0) - mag) : mag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= ctrl_in.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            value_reg <= value_next;
        end
    end

    assign vld_out   = vld_reg;
    assign value_out = value_reg;

endmodule

// ===== hw/rtl/taylor_sine_cosine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taylor_sine_cosine_top
// Fixed-point sine/cosine by short Taylor series with quadrant folding.
// ----------------------------------------------------------------------------
// Input channel s_*: s_op (0 sine, 1 cosine) and s_angle, an unsigned fraction
// of a full turn. Result channel m_*: m_value, signed Q1.RESULT_FRAC_BITS.
// One result word per input word, in order.
// Seven register stages: fold, radians, x^2, x^3/x^4, bias, divide-by-3,
// output. Each input word passes through them in that order to m_valid.
// Throughput is one word per cycle while the receiver does not stall;
// every stage holds its own valid bit.
// The whole pipe advances together whenever the output register is empty or
// being taken, so s_ready = !m_valid || m_ready. If the receiver stalls, the
// pipe freezes with the result held on m_value; nothing is dropped or
// repeated, and bubbles ahead of the output stay where they are.
// Reset (aresetn low, synchronous) clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module taylor_sine_cosine_top #(
    parameter int ANGLE_BITS       = tsc_pkg::ANGLE_BITS_DEF,
    parameter int RESULT_FRAC_BITS = tsc_pkg::RESULT_FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_op,
    input  logic [ANGLE_BITS-1:0]       s_angle,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [tsc_pkg::VALUE_W-1:0] m_value
);

    logic                     en;
    tsc_pkg::ctrl_t           fold_ctrl;
    logic [tsc_pkg::X_W-1:0]  fold_x;
    tsc_pkg::ctrl_t           pow_ctrl;
    logic [tsc_pkg::X_W-1:0]  pow_x;
    logic [tsc_pkg::X2_W-1:0] pow_x2;
    logic [tsc_pkg::P_W-1:0]  pow_p;
    tsc_pkg::ctrl_t           div_ctrl;
    logic [tsc_pkg::X_W-1:0]  div_x;
    logic [tsc_pkg::X2_W-1:0] div_h2;
    logic [tsc_pkg::Q_W-1:0]  div_q;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    tsc_fold #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_fold (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (s_valid),
        .op       (s_op),
        .angle    (s_angle),
        .ctrl_out (fold_ctrl),
        .x_out    (fold_x)
    );

    tsc_pow u_pow (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .ctrl_in  (fold_ctrl),
        .x_in     (fold_x),
        .ctrl_out (pow_ctrl),
        .x_out    (pow_x),
        .x2_out   (pow_x2),
        .p_out    (pow_p)
    );

    tsc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .ctrl_in  (pow_ctrl),
        .x_in     (pow_x),
        .x2_in    (pow_x2),
        .p_in     (pow_p),
        .ctrl_out (div_ctrl),
        .x_out    (div_x),
        .h2_out   (div_h2),
        .q_out    (div_q)
    );

    tsc_out #(
        .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .ctrl_in   (div_ctrl),
        .x_in      (div_x),
        .h2_in     (div_h2),
        .q_in      (div_q),
        .vld_out   (m_valid),
        .value_out (m_value)
    );

endmodule

// ===== hw/rtl/tsc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_port_checker
// Port-level checks for the sine/cosine pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`include "taylor_sine_cosine_top_macros.svh"

module tsc_port_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [tsc_pkg::VALUE_W-1:0] m_value
);

    localparam logic [tsc_pkg::VALUE_W-1:0] MOST_NEG = {1'b1, {(tsc_pkg::VALUE_W-1){1'b0}}};

    // stalled result word holds
    `TSC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_value))
    // a result word only leaves through a handshake
    `TSC_ASSERT_NOW(a_out_leave, $fell(m_valid) && $past(aresetn), $past(m_ready))
    // an empty output register never blocks the input side
    `TSC_ASSERT_NOW(a_in_ready, !m_valid, s_ready)
    // magnitude is saturated before negation, so the most negative code never shows
    `TSC_ASSERT_NOW(a_no_most_neg, m_valid, m_value != MOST_NEG)

endmodule

bind taylor_sine_cosine_top tsc_port_checker u_tsc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_value (m_value)
);
